// ===== hdl/qar_pkg.sv =====
// ---------------------------------------------------------------------------
// qar_pkg: shared types and constants for the quaternion rotate core
// Item layouts, CORDIC angle table and the term tables of both
// Hamilton products.
// ---------------------------------------------------------------------------
package qar_pkg;

    localparam int SINCOS_STEPS  = 16;
    localparam int CORDIC_MAX    = 24;
    localparam int CORDIC_STAGES = (SINCOS_STEPS < CORDIC_MAX) ? SINCOS_STEPS : CORDIC_MAX;

    localparam int IN_W  = 160;
    localparam int OUT_W = 96;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic signed [32:0] ATAN_TAB [CORDIC_MAX] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81
    };

    // point and axis as carried through the pipes
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } qar_geom_t;

    // item handed from front to back: half-angle cos/sin in Q2.30 plus geometry
    typedef struct packed {
        logic signed [32:0] c;
        logic signed [32:0] s;
        qar_geom_t          g;
    } qar_work_t;

    // t = p * (0,v): three terms per component, index 3*comp + n
    // p index 0..3 = r,i,j,k ; v index 0..2 = x,y,z
    localparam int FP_P [12] = '{1, 2, 3,  0, 2, 3,  0, 1, 3,  0, 1, 2};
    localparam int FP_V [12] = '{0, 1, 2,  0, 2, 1,  1, 2, 0,  2, 1, 0};
    localparam bit FP_N [12] = '{1, 1, 1,  0, 0, 1,  0, 1, 0,  0, 0, 1};

    // r = t * conj(p): four terms per output, index 4*out + n
    localparam int SP_T [12] = '{1, 3, 0, 2,  2, 1, 0, 3,  3, 2, 0, 1};
    localparam int SP_P [12] = '{0, 2, 1, 3,  0, 3, 2, 1,  0, 1, 3, 2};
    localparam bit SP_N [12] = '{0, 0, 1, 1,  0, 0, 1, 1,  0, 0, 1, 1};

endpackage

// ===== hdl/qar_front.sv =====
// ---------------------------------------------------------------------------
// qar_front: input side, angle fold and pipelined half-angle CORDIC
// One stage per CORDIC iteration; stalls only when the queue is full.
// ---------------------------------------------------------------------------
module qar_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [qar_pkg::IN_W-1:0] s_tdata,
    input  logic                     q_full,
    output logic                     wr_valid,
    output qar_pkg::qar_work_t       wr_item
);
    import qar_pkg::*;

    localparam int CS = CORDIC_STAGES;

    logic                en;
    logic [CS:0]         vld_reg;
    logic signed [32:0]  x_reg [0:CS];
    logic signed [32:0]  y_reg [0:CS];
    logic signed [32:0]  z_reg [0:CS];
    logic                neg_reg [0:CS];
    qar_geom_t           geo_reg [0:CS];

    qar_geom_t           in_geo;
    logic [15:0]         in_angle;
    logic [16:0]         fold;

    assign en       = !q_full;
    assign s_tready = en;

    assign in_geo.px = s_tdata[31:0];
    assign in_geo.py = s_tdata[63:32];
    assign in_geo.pz = s_tdata[95:64];
    assign in_geo.ax = s_tdata[111:96];
    assign in_geo.ay = s_tdata[127:112];
    assign in_geo.az = s_tdata[143:128];
    assign in_angle  = s_tdata[159:144];

    // fold into the first half turn, cosine sign flips
    assign fold = in_angle[15] ? (17'd65536 - {1'b0, in_angle}) : {1'b0, in_angle};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[CS-1:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= signed'({1'b0, fold, 15'd0});
            neg_reg[0] <= in_angle[15];
            geo_reg[0] <= in_geo;
            for (int k = 1; k <= CS; k++)
            begin
                if (!z_reg[k-1][32])
                begin
                    x_reg[k] <= x_reg[k-1] - (y_reg[k-1] >>> (k-1));
                    y_reg[k] <= y_reg[k-1] + (x_reg[k-1] >>> (k-1));
                    z_reg[k] <= z_reg[k-1] - ATAN_TAB[k-1];
                end
                else
                begin
                    x_reg[k] <= x_reg[k-1] + (y_reg[k-1] >>> (k-1));
                    y_reg[k] <= y_reg[k-1] - (x_reg[k-1] >>> (k-1));
                    z_reg[k] <= z_reg[k-1] + ATAN_TAB[k-1];
                end
                neg_reg[k] <= neg_reg[k-1];
                geo_reg[k] <= geo_reg[k-1];
            end
        end
    end

    assign wr_valid  = en && vld_reg[CS];
    assign wr_item.c = neg_reg[CS] ? -x_reg[CS] : x_reg[CS];
    assign wr_item.s = y_reg[CS];
    assign wr_item.g = geo_reg[CS];

endmodule

// ===== hdl/qar_queue.sv =====
// ---------------------------------------------------------------------------
// qar_queue: short FIFO between front and back
// Register storage, push and pop in the same cycle allowed.
// ---------------------------------------------------------------------------
module qar_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  qar_pkg::qar_work_t push_item,
    input  logic               pop,
    output qar_pkg::qar_work_t pop_item,
    output logic               full,
    output logic               empty
);
    import qar_pkg::*;

    qar_work_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wp_reg;
    logic [QPTR_W-1:0]   rp_reg;
    logic [QPTR_W:0]     cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (cnt_reg == QDEPTH[QPTR_W:0]);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= rp_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= push_item;
    end

endmodule

// ===== hdl/qar_back.sv =====
// ---------------------------------------------------------------------------
// qar_back: quaternion build and the two Hamilton products
// Seven stages, last one is the output register; stalls on m_tready only.
// ---------------------------------------------------------------------------
module qar_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  qar_pkg::qar_work_t        in_item,
    output logic                      in_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [qar_pkg::OUT_W-1:0] m_tdata
);
    import qar_pkg::*;

    logic               en;
    logic [5:0]         vld_reg;
    logic               ov_reg;

    // stage 1: sine times axis
    logic signed [32:0] c1_reg;
    logic signed [48:0] sa1_reg [3];
    logic signed [31:0] v1_reg  [3];
    // stage 2: rounded quaternion, Q.26
    logic signed [29:0] p2_reg  [4];
    logic signed [31:0] v2_reg  [3];
    // stage 3: first product terms
    logic signed [61:0] fp3_reg [12];
    logic signed [29:0] p3_reg  [4];
    // stage 4: t components, Q22.16
    logic signed [37:0] t4_reg  [4];
    logic signed [29:0] p4_reg  [4];
    // stage 5: split partial products of the second product
    logic signed [49:0] hi5_reg [12];
    logic signed [48:0] lo5_reg [12];
    // stage 6: signed terms
    logic signed [67:0] tm6_reg [12];
    // stage 7: output
    logic [31:0]        r_reg   [3];

    logic signed [33:0] c_rnd;
    logic signed [49:0] sa_rnd  [3];
    logic signed [63:0] fsum    [4];
    logic signed [67:0] term    [12];
    logic signed [69:0] osum    [3];
    logic signed [43:0] ores    [3];
    logic [31:0]        osat    [3];

    assign en       = !ov_reg || m_tready;
    assign in_pop   = en && in_valid;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {r_reg[2], r_reg[1], r_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
            ov_reg  <= vld_reg[5];
        end
    end

    always_comb
    begin
        c_rnd = {c1_reg[32], c1_reg} + 34'sd8;
        for (int n = 0; n < 3; n++)
            sa_rnd[n] = {sa1_reg[n][48], sa1_reg[n]} + 50'sd131072;
        for (int m = 0; m < 4; m++)
        begin
            fsum[m] = (64'sd1 <<< 25);
            for (int n = 0; n < 3; n++)
            begin
                if (FP_N[3*m+n])
                    fsum[m] = fsum[m] - 64'(fp3_reg[3*m+n]);
                else
                    fsum[m] = fsum[m] + 64'(fp3_reg[3*m+n]);
            end
        end
        for (int n = 0; n < 12; n++)
            term[n] = (68'(hi5_reg[n]) <<< 18) + 68'(lo5_reg[n]);
        for (int o = 0; o < 3; o++)
        begin
            osum[o] = (70'sd1 <<< 25);
            for (int n = 0; n < 4; n++)
                osum[o] = osum[o] + 70'(tm6_reg[4*o+n]);
            ores[o] = osum[o][69:26];
            if (ores[o] > 44'sd2147483647)
                osat[o] = 32'h7FFF_FFFF;
            else if (ores[o] < -44'sd2147483648)
                osat[o] = 32'h8000_0000;
            else
                osat[o] = ores[o][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg     <= in_item.c;
            sa1_reg[0] <= in_item.s * in_item.g.ax;
            sa1_reg[1] <= in_item.s * in_item.g.ay;
            sa1_reg[2] <= in_item.s * in_item.g.az;
            v1_reg[0]  <= in_item.g.px;
            v1_reg[1]  <= in_item.g.py;
            v1_reg[2]  <= in_item.g.pz;

            p2_reg[0] <= c_rnd[33:4];
            for (int n = 0; n < 3; n++)
            begin
                p2_reg[n+1] <= sa_rnd[n][47:18];
                v2_reg[n]   <= v1_reg[n];
            end

            for (int n = 0; n < 12; n++)
                fp3_reg[n] <= p2_reg[FP_P[n]] * v2_reg[FP_V[n]];
            p3_reg <= p2_reg;

            for (int m = 0; m < 4; m++)
                t4_reg[m] <= fsum[m][63:26];
            p4_reg <= p3_reg;

            // t = hi * 2^18 + lo, lo unsigned
            for (int n = 0; n < 12; n++)
            begin
                hi5_reg[n] <= signed'(t4_reg[SP_T[n]][37:18]) * p4_reg[SP_P[n]];
                lo5_reg[n] <= signed'({1'b0, t4_reg[SP_T[n]][17:0]}) * p4_reg[SP_P[n]];
            end

            for (int n = 0; n < 12; n++)
                tm6_reg[n] <= SP_N[n] ? -term[n] : term[n];

            for (int o = 0; o < 3; o++)
                r_reg[o] <= osat[o];
        end
    end

endmodule

// ===== hdl/quaternion_axis_angle_rotate_core.sv =====
// ---------------------------------------------------------------------------
// quaternion_axis_angle_rotate_core: rotate a point about an axis by an angle
// Builds p = (cos h, sin h * axis) with a pipelined CORDIC and returns the
// imaginary part of p * (0,v) * conj(p), saturated to Q16.16.
// ---------------------------------------------------------------------------
//
//  channel  dir  fields (lowest bit first)
//  s_axis   in   point_x[31:0] point_y[63:32] point_z[95:64] axis_x[111:96]
//                axis_y[127:112] axis_z[143:128] angle[159:144]
//  m_axis   out  rotated_x[31:0] rotated_y[63:32] rotated_z[95:64]
//
//  One item per cycle sustained while neither pipe stalls. An item runs through
//  the front's CORDIC stages and is pushed into the queue, is popped from it
//  into the back's first stage and then passes on to the back's seventh stage,
//  the output register.
//  rst_n clears only valid bits and the queue pointers and count.
//  The front stalls only while the 4-entry queue is full; the back stalls
//  only while an output item sits unaccepted.
//
module quaternion_axis_angle_rotate_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // point_x, point_y, point_z, axis_x, axis_y, axis_z, angle
    input  logic [qar_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [qar_pkg::OUT_W-1:0] m_tdata
);
    import qar_pkg::*;

    logic      wr_valid;
    qar_work_t wr_item;
    logic      q_full;
    logic      q_empty;
    logic      rd_pop;
    qar_work_t rd_item;

    // front: accept, fold the angle, CORDIC
    qar_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .wr_valid (wr_valid),
        .wr_item  (wr_item)
    );

    // decouples the two pipes
    qar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (wr_valid),
        .push_item (wr_item),
        .pop       (rd_pop),
        .pop_item  (rd_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: quaternion products and output register
    qar_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .in_item  (rd_item),
        .in_pop   (rd_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
